// ===== rtl/k1c_pkg.sv =====
// Shared types and constants for the KEY1-style block cipher.
`timescale 1ns / 1ps

package k1c_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned IDX_W      = 11;
    localparam int unsigned REQ_W      = 2;
    localparam int unsigned P_WORDS    = 18;
    localparam int unsigned P_IDX_W    = $clog2(P_WORDS);
    localparam int unsigned SBOX_NUM   = 4;
    localparam int unsigned SBOX_DEPTH = 256;
    localparam int unsigned SBOX_AW    = $clog2(SBOX_DEPTH);
    localparam int unsigned S0_BASE    = 18;
    localparam int unsigned TABLE_SPAN = SBOX_NUM * SBOX_DEPTH;
    localparam int unsigned ROUNDS     = 16;
    localparam int unsigned CNT_W      = $clog2(ROUNDS);
    localparam int unsigned WHITE_A    = 16;
    localparam int unsigned WHITE_B    = 17;
    localparam int unsigned DEC_LO     = 1;
    localparam int unsigned DEC_HI     = 0;

    localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ENC  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DEC  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_ROUND = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

endpackage

// ===== rtl/k1c_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module k1c_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/k1c_round.sv =====
// Feistel round function: S-box combine and mix into the other half.
`timescale 1ns / 1ps

module k1c_round (
    input  logic [k1c_pkg::SBOX_NUM-1:0][k1c_pkg::WORD_W-1:0] sbox_data,
    input  logic [k1c_pkg::WORD_W-1:0]                         y_in,
    output logic [k1c_pkg::WORD_W-1:0]                         x_out
);

    logic [k1c_pkg::WORD_W-1:0] sum01;
    logic [k1c_pkg::WORD_W-1:0] mix2;
    logic [k1c_pkg::WORD_W-1:0] f_val;

    always_comb begin
        sum01 = sbox_data[0] + sbox_data[1];
        mix2  = sum01 ^ sbox_data[2];
        f_val = mix2 + sbox_data[3];
        x_out = f_val ^ y_in;
    end

endmodule

// ===== rtl/key1_block_cipher.sv =====
// Top level of the KEY1-style 64-bit block cipher with round sequencer.
// A load item writes one key table word and gives no result;
// indexes 0-17 go to the round-word registers, 18-1041 to the four S-box RAMs,
// and higher indexes are dropped. An encrypt or decrypt item runs 16 rounds,
// each in two states (ISSUE forms the round input and addresses the S-boxes,
// ROUND takes the registered S-box read through the round function), then
// DONE applies the whitening and loads the result; the sequencer then returns
// to idle, where the next item is accepted. One item is in work at a time;
// s_ready is low while it runs. A finished result waits in the output
// register, and the next item is taken meanwhile; the whitening cycle of a
// later block holds until that result is taken. Every table word a cipher
// item uses must have been loaded since reset.
`timescale 1ns / 1ps

module key1_block_cipher (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [k1c_pkg::REQ_W-1:0]           s_req_type,
    input  logic [k1c_pkg::IDX_W-1:0]           s_table_index,
    input  logic [k1c_pkg::WORD_W-1:0]          s_table_word,
    input  logic [k1c_pkg::WORD_W-1:0]          s_block_lo,
    input  logic [k1c_pkg::WORD_W-1:0]          s_block_hi,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [k1c_pkg::WORD_W-1:0]          m_result_lo,
    output logic [k1c_pkg::WORD_W-1:0]          m_result_hi
);

    localparam int unsigned W  = k1c_pkg::WORD_W;
    localparam int unsigned NB = k1c_pkg::SBOX_NUM;
    localparam int unsigned AW = k1c_pkg::SBOX_AW;

    k1c_pkg::state_t state_reg, state_next;

    logic [W-1:0]                  x_reg, x_next;
    logic [W-1:0]                  y_reg, y_next;
    logic [W-1:0]                  z_reg, z_next;
    logic [k1c_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                          dec_reg, dec_next;
    logic                          m_valid_reg, m_valid_next;
    logic [W-1:0]                  m_lo_reg, m_lo_next;
    logic [W-1:0]                  m_hi_reg, m_hi_next;
    logic [W-1:0]                  p_reg [k1c_pkg::P_WORDS];

    logic                          accept;
    logic                          load_fire;
    logic [k1c_pkg::IDX_W-1:0]     box_off;
    logic                          p_hit;
    logic                          box_hit;
    logic [NB-1:0]                 box_we;
    logic [k1c_pkg::P_IDX_W-1:0]   pidx;
    logic [W-1:0]                  z_comb;
    logic [NB-1:0][W-1:0]          sbox_rdata;
    logic [W-1:0]                  x_round;

    assign s_ready     = (state_reg == k1c_pkg::ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign load_fire   = accept && (s_req_type == k1c_pkg::REQ_LOAD);
    assign m_valid     = m_valid_reg;
    assign m_result_lo = m_lo_reg;
    assign m_result_hi = m_hi_reg;

    // Load address decode: round words below the boxes, then four boxes.
    assign box_off = s_table_index - k1c_pkg::IDX_W'(k1c_pkg::S0_BASE);
    assign p_hit   = (s_table_index < k1c_pkg::IDX_W'(k1c_pkg::S0_BASE));
    assign box_hit = !p_hit && (box_off < k1c_pkg::IDX_W'(k1c_pkg::TABLE_SPAN));

    always_comb begin
        for (int i = 0; i < NB; i++) begin
            box_we[i] = load_fire && box_hit && (box_off[AW +: 2] == 2'(i));
        end
    end

    always_ff @(posedge aclk) begin
        if (load_fire && p_hit) begin
            p_reg[s_table_index[k1c_pkg::P_IDX_W-1:0]] <= s_table_word;
        end
    end

    // Round word select: forward for encrypt, reverse from P[17] for decrypt.
    assign pidx   = dec_reg ? (k1c_pkg::P_IDX_W'(k1c_pkg::WHITE_B)
                               - k1c_pkg::P_IDX_W'(cnt_reg))
                            : k1c_pkg::P_IDX_W'(cnt_reg);
    assign z_comb = p_reg[pidx] ^ x_reg;

    for (genvar g = 0; g < NB; g++) begin : g_sbox
        k1c_ram #(
            .WIDTH (W),
            .DEPTH (k1c_pkg::SBOX_DEPTH)
        ) u_sbox (
            .aclk  (aclk),
            .we    (box_we[g]),
            .waddr (box_off[AW-1:0]),
            .wdata (s_table_word),
            .raddr (z_comb[W-1-AW*g -: AW]),
            .rdata (sbox_rdata[g])
        );
    end

    k1c_round u_round (
        .sbox_data (sbox_rdata),
        .y_in      (y_reg),
        .x_out     (x_round)
    );

    always_comb begin
        state_next   = state_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        cnt_next     = cnt_reg;
        dec_next     = dec_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_lo_next    = m_lo_reg;
        m_hi_next    = m_hi_reg;
        unique case (state_reg)
            k1c_pkg::ST_IDLE: begin
                if (accept && (s_req_type == k1c_pkg::REQ_ENC
                               || s_req_type == k1c_pkg::REQ_DEC)) begin
                    x_next     = s_block_hi;
                    y_next     = s_block_lo;
                    dec_next   = (s_req_type == k1c_pkg::REQ_DEC);
                    cnt_next   = '0;
                    state_next = k1c_pkg::ST_ISSUE;
                end
            end
            k1c_pkg::ST_ISSUE: begin
                z_next     = z_comb;
                state_next = k1c_pkg::ST_ROUND;
            end
            k1c_pkg::ST_ROUND: begin
                x_next   = x_round;
                y_next   = z_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == k1c_pkg::CNT_W'(k1c_pkg::ROUNDS - 1)) begin
                    state_next = k1c_pkg::ST_DONE;
                end else begin
                    state_next = k1c_pkg::ST_ISSUE;
                end
            end
            k1c_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (dec_reg) begin
                        m_lo_next = x_reg ^ p_reg[k1c_pkg::DEC_LO];
                        m_hi_next = y_reg ^ p_reg[k1c_pkg::DEC_HI];
                    end else begin
                        m_lo_next = x_reg ^ p_reg[k1c_pkg::WHITE_A];
                        m_hi_next = y_reg ^ p_reg[k1c_pkg::WHITE_B];
                    end
                    state_next = k1c_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = k1c_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= k1c_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        cnt_reg  <= cnt_next;
        dec_reg  <= dec_next;
        m_lo_reg <= m_lo_next;
        m_hi_reg <= m_hi_next;
    end

endmodule
